>>> rtl/core/tfs_pkg.sv
// types and constants shared by the typed field serializer
`timescale 1ns / 1ps
`default_nettype none

package tfs_pkg;

	typedef enum logic [3:0] {
		OP_U8       = 4'd0,
		OP_U16      = 4'd1,
		OP_U32      = 4'd2,
		OP_U64      = 4'd3,
		OP_VARINT32 = 4'd4,
		OP_VARINT64 = 4'd5,
		OP_ZIGZAG32 = 4'd6,
		OP_ZIGZAG64 = 4'd7,
		OP_BOOL     = 4'd8
	} op_t;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	localparam logic [6:0] GROUP_MASK = 7'h7f;

	// one classified request: fixed data is left aligned, varint data right aligned
	typedef struct packed {
		logic        varint;
		logic [2:0]  nleft;
		logic [63:0] data;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

`default_nettype wire

>>> rtl/core/tfs_front.sv
// front end: classifies a request into a byte job
`timescale 1ns / 1ps
`default_nettype none

module tfs_front (
	input  wire logic [3:0]     operation,
	input  wire logic [63:0]    value,
	output tfs_pkg::job_t       job,
	output logic                job_ok
);
	import tfs_pkg::*;

	logic [31:0] low32;
	logic [31:0] zz32;
	logic [63:0] zz64;

	assign low32 = value[31:0];
	assign zz32  = {low32[30:0], 1'b0} ^ {32{low32[31]}};
	assign zz64  = {value[62:0], 1'b0} ^ {64{value[63]}};

	always_comb begin
		job_ok     = 1'b1;
		job.varint = 1'b0;
		job.nleft  = 3'd0;
		job.data   = 64'd0;
		unique case (operation)
			OP_U8: begin
				job.data = {value[7:0], 56'd0};
			end
			OP_U16: begin
				job.nleft = 3'd1;
				job.data  = {value[15:0], 48'd0};
			end
			OP_U32: begin
				job.nleft = 3'd3;
				job.data  = {value[31:0], 32'd0};
			end
			OP_U64: begin
				job.nleft = 3'd7;
				job.data  = value;
			end
			OP_VARINT32: begin
				job.varint = 1'b1;
				job.data   = {32'd0, low32};
			end
			OP_VARINT64: begin
				job.varint = 1'b1;
				job.data   = value;
			end
			OP_ZIGZAG32: begin
				job.varint = 1'b1;
				job.data   = {32'd0, zz32};
			end
			OP_ZIGZAG64: begin
				job.varint = 1'b1;
				job.data   = zz64;
			end
			OP_BOOL: begin
				job.data = {7'd0, |value, 56'd0};
			end
			default: begin
				job_ok = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/core/tfs_queue.sv
// short job queue between front and back
`timescale 1ns / 1ps
`default_nettype none

module tfs_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_en,
	input  wire tfs_pkg::job_t         wr_data,
	input  wire logic                  rd_en,
	output tfs_pkg::job_t              rd_data,
	output tfs_pkg::queue_status_t     status
);
	import tfs_pkg::*;

	job_t                slot_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wptr_q;
	logic [QUEUE_AW-1:0] rptr_q;
	logic [QUEUE_CW-1:0] count_q;
	logic                do_wr;
	logic                do_rd;

	assign status.full  = (count_q == QUEUE_CW'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign do_wr        = wr_en && !status.full;
	assign do_rd        = rd_en && !status.empty;
	assign rd_data      = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/tfs_back.sv
// back end: emits one encoded byte per cycle into an output register while that register is free or popped
`timescale 1ns / 1ps
`default_nettype none

module tfs_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire tfs_pkg::job_t         q_data,
	input  wire tfs_pkg::queue_status_t q_status,
	output logic                       q_pop,
	input  wire logic                  pop,
	output logic                       empty,
	output logic [7:0]                 out_byte,
	output logic                       last
);
	import tfs_pkg::*;

	logic        busy_q;
	job_t        job_q;
	logic        ovalid_q;
	logic [7:0]  obyte_q;
	logic        olast_q;
	logic        out_free;
	logic        advance;
	logic        more;
	logic [7:0]  cur_byte;
	logic        cur_last;

	assign more     = |job_q.data[63:7];
	assign cur_byte = job_q.varint ? {more, job_q.data[6:0] & GROUP_MASK} : job_q.data[63:56];
	assign cur_last = job_q.varint ? !more : (job_q.nleft == 3'd0);
	assign out_free = !ovalid_q || pop;
	assign advance  = busy_q && out_free;
	assign q_pop    = (!busy_q || (advance && cur_last)) && !q_status.empty;

	assign empty    = !ovalid_q;
	assign out_byte = obyte_q;
	assign last     = olast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (out_free) begin
				ovalid_q <= busy_q;
			end
			if (!busy_q || (advance && cur_last)) begin
				busy_q <= !q_status.empty;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			obyte_q <= cur_byte;
			olast_q <= cur_last;
		end
		if (q_pop) begin
			job_q <= q_data;
		end else if (advance) begin
			if (job_q.varint) begin
				job_q.data <= {7'd0, job_q.data[63:7]};
			end else begin
				job_q.data  <= {job_q.data[55:0], 8'd0};
				job_q.nleft <= job_q.nleft - 3'd1;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/typed_field_serializer_unit.sv
// top level of the typed field serializer
//
//  channel   | handshake      | payload
//  ----------+----------------+-------------------
//  request   | push / full    | operation, value
//  result    | pop / empty    | out_byte, last
//
// one result byte per cycle while results are popped: a request yields 1, 2, 4 or 8 bytes
// for fixed kinds, 1 to 5 or 1 to 10 bytes for varint kinds, produced by the byte emitter in the back end
// requests are taken every cycle until the two-entry job queue fills
// unused operation codes are accepted and dropped
// reset clears the queue, the emitter and the output register
`timescale 1ns / 1ps
`default_nettype none

module typed_field_serializer_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [3:0]  operation,
	input  wire logic [63:0] value,
	output logic             empty,
	input  wire logic        pop,
	output logic [7:0]       out_byte,
	output logic             last
);
	import tfs_pkg::*;

	job_t          f_job;
	logic          f_ok;
	job_t          q_data;
	queue_status_t q_status;
	logic          q_pop;

	assign full = q_status.full;

	tfs_front u_front (
		.operation (operation),
		.value     (value),
		.job       (f_job),
		.job_ok    (f_ok)
	);

	tfs_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push && f_ok),
		.wr_data (f_job),
		.rd_en   (q_pop),
		.rd_data (q_data),
		.status  (q_status)
	);

	tfs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_data   (q_data),
		.q_status (q_status),
		.q_pop    (q_pop),
		.pop      (pop),
		.empty    (empty),
		.out_byte (out_byte),
		.last     (last)
	);

endmodule

`default_nettype wire
